// ===== hdl/mbd_pkg.sv =====
// Package for the mipmap box downsampler: shared types, widths and state codes.
package mbd_pkg;

   // Fixed field widths of the item and configuration ports
   localparam int unsigned PortChanBits  = 16;
   localparam int unsigned LevelBits     = 4;
   localparam int unsigned PosBits       = 11;
   localparam int unsigned CsrDataBits   = 13;
   localparam int unsigned CsrIndexBits  = 2;

   // Register indexes of the configuration port
   typedef enum logic [CsrIndexBits-1:0] {
      CSR_BASE_WIDTH  = 2'd0,
      CSR_BASE_HEIGHT = 2'd1
   } csr_index_type;

   // Sequencer states of the back end
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_READ,
      ST_EMIT,
      ST_FLUSH
   } back_state_type;

   // One base pixel as it arrives on the port
   typedef struct packed {
      logic [PortChanBits-1:0] red;
      logic [PortChanBits-1:0] green;
      logic [PortChanBits-1:0] blue;
      logic [PortChanBits-1:0] alpha;
   } pixel_type;

   // One result as it leaves on the port
   typedef struct packed {
      logic [LevelBits-1:0]    level;
      logic [PosBits-1:0]      col;
      logic [PosBits-1:0]      row;
      logic [PortChanBits-1:0] red;
      logic [PortChanBits-1:0] green;
      logic [PortChanBits-1:0] blue;
      logic [PortChanBits-1:0] alpha;
      logic                    last_of_run;
      logic                    chain_done;
   } result_type;

endpackage

// ===== hdl/mbd_if.sv =====
// Handshake interfaces for the pixel request channel and the result channel.
interface mbd_req_if;
   import mbd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [PortChanBits-1:0] red;
   logic [PortChanBits-1:0] green;
   logic [PortChanBits-1:0] blue;
   logic [PortChanBits-1:0] alpha;
   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [LevelBits-1:0]    level;
   logic [PosBits-1:0]      col;
   logic [PosBits-1:0]      row;
   logic [PortChanBits-1:0] out_red;
   logic [PortChanBits-1:0] out_green;
   logic [PortChanBits-1:0] out_blue;
   logic [PortChanBits-1:0] out_alpha;
   logic                    last_of_run;
   logic                    chain_done;
   modport source (output valid, output level, output col, output row, output out_red,
                   output out_green, output out_blue, output out_alpha,
                   output last_of_run, output chain_done, input ready);
   modport sink   (input valid, input level, input col, input row, input out_red,
                   input out_green, input out_blue, input out_alpha,
                   input last_of_run, input chain_done, output ready);
endinterface

// ===== hdl/mipmap_box_downsample.sv =====
// Top level of the streaming 2x2 box-filter mipmap generator.
// An item passes through the registered input queue. The back end then steps through
// ST_LOOK and ST_EMIT per mip level it completes (plus ST_READ for a pair-sum RAM read),
// then ends in ST_FLUSH; it takes the next item only from ST_IDLE, once the last is done.
// A formed result waits pending; the next ST_EMIT or ST_FLUSH outputs it, later under stalls.
// Reset clears positions and geometry to a 1x1 base; pair-sum RAM needs no clearing.
module mipmap_box_downsample
   import mbd_pkg::*;
#(
   parameter int unsigned MAX_SIDE     = 4096,
   parameter int unsigned MAX_LEVELS   = 12,
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data,
   mbd_req_if.sink                 req_ch,
   mbd_rsp_if.source               rsp_ch
);
   logic      q_valid, q_ready;
   pixel_type q_pixel;

   mbd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_pixel (q_pixel),
      .q_ready (q_ready)
   );

   mbd_back #(
      .MaxSide     (MAX_SIDE),
      .MaxLevels   (MAX_LEVELS),
      .ChannelBits (CHANNEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_pixel   (q_pixel),
      .q_ready   (q_ready),
      .rsp_ch    (rsp_ch)
   );
endmodule

// ===== hdl/mbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mbd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/mbd_front.sv =====
// Front end: accepts base pixels and queues them (two entries) for the back end.
module mbd_front
   import mbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mbd_req_if.sink   req_ch,
   output logic      q_valid,
   output pixel_type q_pixel,
   input  logic      q_ready
);
   pixel_type  slot_ff [2];
   pixel_type  slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push    = req_ch.valid && req_ch.ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop     = q_valid && q_ready;
   assign q_pixel = slot_ff[0];

   // Shift queue: head in slot 0
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_ff - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = '{red: req_ch.red, green: req_ch.green,
                                  blue: req_ch.blue, alpha: req_ch.alpha};
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   // Queue never overflows and never pops empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("front queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");
endmodule

// ===== hdl/mbd_back.sv =====
// Back end: walks one pixel down the mip levels, keeps pair sums and emits results.
module mbd_back
   import mbd_pkg::*;
#(
   parameter int unsigned MaxSide     = 4096,
   parameter int unsigned MaxLevels   = 12,
   parameter int unsigned ChannelBits = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data,
   input  logic                    q_valid,
   input  pixel_type               q_pixel,
   output logic                    q_ready,
   mbd_rsp_if.source               rsp_ch
);
   localparam int unsigned XW = $clog2(MaxSide);
   localparam int unsigned SW = XW + 1;
   localparam int unsigned CB = ChannelBits;
   localparam int unsigned HB = CB + 1;
   localparam int unsigned TB = CB + 2;
   localparam int unsigned RamDepth = MaxSide - 1;
   localparam int unsigned AW = $clog2(RamDepth);

   typedef logic [CB-1:0] chan_type;
   typedef logic [HB-1:0] half_type;
   typedef logic [TB-1:0] tot_type;

   back_state_type state_ff, state_in;

   // Geometry
   logic [SW-1:0]        w_ff, w_in, h_ff, h_in;
   logic [LevelBits-1:0] levels_ff, levels_in;

   // Per-level position and held pixel
   logic [XW-1:0] col_ff [MaxLevels];
   logic [XW-1:0] col_in [MaxLevels];
   logic [XW-1:0] row_ff [MaxLevels];
   logic [XW-1:0] row_in [MaxLevels];
   chan_type      held_ff [MaxLevels][4];
   chan_type      held_in [MaxLevels][4];

   // Work registers
   logic [LevelBits-1:0] s_ff, s_in;
   chan_type             p_ff [4];
   chan_type             p_in [4];
   half_type             hs_ff [4];
   half_type             hs_in [4];
   tot_type              tot_ff [4];
   tot_type              tot_in [4];
   logic                 n4_ff, n4_in;
   logic [XW-1:0]        dx_ff, dx_in, dy_ff, dy_in;

   // Pending result and output register
   logic       pend_v_ff, pend_v_in;
   result_type pend_ff, pend_in;
   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;

   // RAM port
   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_addr;
   logic [4*HB-1:0] ram_wdata, ram_rdata;

   // Level geometry helpers
   logic [SW-1:0] sw, sh, dw, dh, ws, hs_side, wd, hd;
   logic [XW-1:0] x, y;
   logic [SW-1:0] off_full;
   logic          out_free, take;
   logic [SW-1:0] clamped;
   logic [SW-1:0] side_max;
   logic [LevelBits-1:0] lg;
   logic [LevelBits-1:0] s_next;
   chan_type      mean [4];

   mbd_ram #(.Width(4 * HB), .Depth(RamDepth)) u_pair_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign take     = out_v_ff && rsp_ch.ready;
   assign out_free = !out_v_ff || rsp_ch.ready;
   assign s_next   = s_ff + LevelBits'(1);

   // Side lengths of source and destination level
   always_comb begin
      ws      = w_ff >> s_ff;
      hs_side = h_ff >> s_ff;
      wd      = w_ff >> s_next;
      hd      = h_ff >> s_next;
      sw = (ws == '0) ? SW'(1) : ws;
      sh = (hs_side == '0) ? SW'(1) : hs_side;
      dw = (wd == '0) ? SW'(1) : wd;
      dh = (hd == '0) ? SW'(1) : hd;
      off_full = SW'(MaxSide) - (SW'(MaxSide) >> s_ff);
   end

   // Clamp of a written side and level count from the next geometry
   always_comb begin
      if (csr_data == '0) begin
         clamped = SW'(1);
      end else if (32'(csr_data) > MaxSide) begin
         clamped = SW'(MaxSide);
      end else begin
         clamped = SW'(csr_data);
      end
      w_in = w_ff;
      h_in = h_ff;
      if (csr_we && csr_index == CSR_BASE_WIDTH) begin
         w_in = clamped;
      end
      if (csr_we && csr_index == CSR_BASE_HEIGHT) begin
         h_in = clamped;
      end
      side_max = (w_in > h_in) ? w_in : h_in;
      lg = '0;
      for (int i = 0; i < SW; i++) begin
         if (side_max[i]) begin
            lg = LevelBits'(i);
         end
      end
      levels_in = (32'(lg) > MaxLevels) ? LevelBits'(MaxLevels) : lg;
   end

   // Rounded mean, half up
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mean[c] = n4_ff ? CB'((tot_ff[c] + TB'(2)) >> 2)
                         : CB'((tot_ff[c] + TB'(1)) >> 1);
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      s_in      = s_ff;
      p_in      = p_ff;
      hs_in     = hs_ff;
      tot_in    = tot_ff;
      n4_in     = n4_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = take ? 1'b0 : out_v_ff;
      out_in    = out_ff;
      q_ready   = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      x         = col_ff[s_ff[$clog2(MaxLevels > 1 ? MaxLevels : 2)-1:0]];
      y         = row_ff[s_ff[$clog2(MaxLevels > 1 ? MaxLevels : 2)-1:0]];
      ram_addr  = AW'(off_full + SW'(dx_ff));
      ram_wdata = {hs_in[0], hs_in[1], hs_in[2], hs_in[3]};

      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               p_in[0]  = CB'(q_pixel.red);
               p_in[1]  = CB'(q_pixel.green);
               p_in[2]  = CB'(q_pixel.blue);
               p_in[3]  = CB'(q_pixel.alpha);
               s_in     = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (s_ff >= levels_ff) begin
               state_in = ST_FLUSH;
            end else begin
               if (SW'(x) >= sw || SW'(y) >= sh) begin
                  x = '0;
                  y = '0;
               end
               // Advance the raster position of this level
               if (SW'(x) + SW'(1) >= sw) begin
                  col_in[s_ff] = '0;
                  row_in[s_ff] = (SW'(y) + SW'(1) >= sh) ? '0 : y + XW'(1);
               end else begin
                  col_in[s_ff] = x + XW'(1);
                  row_in[s_ff] = y;
               end
               dx_in    = x >> 1;
               dy_in    = y >> 1;
               ram_addr = AW'(off_full + SW'(dx_in));
               n4_in    = (sw != SW'(1));
               state_in = ST_FLUSH;
               if (SW'(dx_in) < dw && SW'(dy_in) < dh) begin
                  // Horizontal pair
                  if (sw != SW'(1) && !x[0]) begin
                     for (int c = 0; c < 4; c++) begin
                        held_in[s_ff][c] = p_ff[c];
                     end
                  end else begin
                     for (int c = 0; c < 4; c++) begin
                        hs_in[c] = (sw == SW'(1)) ? HB'(p_ff[c])
                                 : HB'(held_ff[s_ff][c]) + HB'(p_ff[c]);
                     end
                     ram_wdata = {hs_in[0], hs_in[1], hs_in[2], hs_in[3]};
                     // Vertical pair
                     if (sh == SW'(1)) begin
                        for (int c = 0; c < 4; c++) begin
                           tot_in[c] = TB'(hs_in[c]);
                        end
                        n4_in    = 1'b0;
                        state_in = ST_EMIT;
                     end else if (!y[0]) begin
                        ram_we = 1'b1;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            for (int c = 0; c < 4; c++) begin
               tot_in[c] = TB'(ram_rdata[(3 - c) * HB +: HB]) + TB'(hs_ff[c]);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_in             = pend_ff;
                  out_in.last_of_run = 1'b0;
                  out_v_in           = 1'b1;
               end
               pend_v_in           = 1'b1;
               pend_in.level       = s_next;
               pend_in.col         = PosBits'(dx_ff);
               pend_in.row         = PosBits'(dy_ff);
               pend_in.red         = PortChanBits'(mean[0]);
               pend_in.green       = PortChanBits'(mean[1]);
               pend_in.blue        = PortChanBits'(mean[2]);
               pend_in.alpha       = PortChanBits'(mean[3]);
               pend_in.last_of_run = 1'b0;
               pend_in.chain_done  = (s_next == levels_ff);
               p_in                = mean;
               s_in                = s_next;
               state_in            = ST_LOOK;
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in             = pend_ff;
               out_in.last_of_run = 1'b1;
               out_v_in           = 1'b1;
               pend_v_in          = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A write to the width or height register restarts the frame
      if (csr_we && (csr_index == CSR_BASE_WIDTH || csr_index == CSR_BASE_HEIGHT)) begin
         for (int l = 0; l < MaxLevels; l++) begin
            col_in[l] = '0;
            row_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         w_ff      <= SW'(1);
         h_ff      <= SW'(1);
         levels_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         s_ff      <= '0;
         for (int l = 0; l < MaxLevels; l++) begin
            col_ff[l] <= '0;
            row_ff[l] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         levels_ff <= levels_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         s_ff      <= s_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
      held_ff <= held_in;
      p_ff    <= p_in;
      hs_ff   <= hs_in;
      tot_ff  <= tot_in;
      n4_ff   <= n4_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.level       = out_ff.level;
   assign rsp_ch.col         = out_ff.col;
   assign rsp_ch.row         = out_ff.row;
   assign rsp_ch.out_red     = out_ff.red;
   assign rsp_ch.out_green   = out_ff.green;
   assign rsp_ch.out_blue    = out_ff.blue;
   assign rsp_ch.out_alpha   = out_ff.alpha;
   assign rsp_ch.last_of_run = out_ff.last_of_run;
   assign rsp_ch.chain_done  = out_ff.chain_done;

   // No result stays pending once the sequencer is idle
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff) else $error("pending result left behind");
   // A result is only formed for a generated level
   a_emit_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> s_ff < levels_ff) else $error("emit beyond last level");
   // A RAM read is always followed by the sum step
   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_EMIT) else $error("read not consumed");
endmodule

// ===== sim/tb_mipmap_box_downsample.sv =====
// Self-checking testbench for the streaming 2x2 box-filter mipmap generator.
module tb_mipmap_box_downsample;
   import mbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SideMax   = 4096;
   localparam int unsigned LevelsMax = 12;
   localparam int unsigned StallLimit = 5000;
   localparam int unsigned SettleCycles = 60;

   // Expected mip pixels and the generator state that produces them
   class mip_scoreboard;
      result_type  mip_queue[$];
      int unsigned errors;
      int unsigned inputs_seen;
      int unsigned results_seen;
      int unsigned cfg_width;
      int unsigned cfg_height;
      int unsigned num_lvls;
      int unsigned lw[LevelsMax+1];
      int unsigned lh[LevelsMax+1];
      int unsigned col_pos[LevelsMax];
      int unsigned row_pos[LevelsMax];
      int unsigned held[LevelsMax][4];
      int unsigned pair_sum[LevelsMax][SideMax/2][4];

      function new();
         cfg_width = 1;
         cfg_height = 1;
         errors = 0;
         inputs_seen = 0;
         results_seen = 0;
         restart();
      endfunction

      // Clamp the sides, derive level sizes and clear all positions
      function void restart();
         int unsigned w, h, m;
         w = (cfg_width < 1) ? 1 : (cfg_width > SideMax ? SideMax : cfg_width);
         h = (cfg_height < 1) ? 1 : (cfg_height > SideMax ? SideMax : cfg_height);
         m = (w > h) ? w : h;
         num_lvls = 0;
         while (m > 1 && num_lvls < LevelsMax) begin
            m = m >> 1;
            num_lvls++;
         end
         lw[0] = w;
         lh[0] = h;
         for (int i = 1; i <= LevelsMax; i++) begin
            lw[i] = (lw[i-1] / 2 < 1) ? 1 : lw[i-1] / 2;
            lh[i] = (lh[i-1] / 2 < 1) ? 1 : lh[i-1] / 2;
         end
         for (int i = 0; i < LevelsMax; i++) begin
            col_pos[i] = 0;
            row_pos[i] = 0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [CsrDataBits-1:0] value);
         if (idx == CSR_BASE_WIDTH) cfg_width = 32'(value);
         else if (idx == CSR_BASE_HEIGHT) cfg_height = 32'(value);
         else return;
         restart();
      endfunction

      // Walk one base pixel down the chain, queueing every mip pixel it completes
      function void note_input(pixel_type px);
         int unsigned p[4], hs[4], tot[4];
         int unsigned x, y, dx, dy, n, sw, sh;
         bit have_h, emit;
         result_type r, burst[$];
         p[0] = 32'(px.red); p[1] = 32'(px.green); p[2] = 32'(px.blue); p[3] = 32'(px.alpha);
         inputs_seen++;
         for (int s = 0; s < num_lvls; s++) begin
            sw = lw[s]; sh = lh[s];
            x = col_pos[s]; y = row_pos[s];
            if (x >= sw || y >= sh) begin
               x = 0; y = 0;
            end
            if (x + 1 >= sw) begin
               col_pos[s] = 0;
               row_pos[s] = (y + 1 >= sh) ? 0 : y + 1;
            end else begin
               col_pos[s] = x + 1;
               row_pos[s] = y;
            end
            dx = x >> 1;
            dy = y >> 1;
            if (dx >= lw[s+1] || dy >= lh[s+1]) break;
            have_h = 0;
            emit = 0;
            n = 0;
            // horizontal pairing
            if (sw == 1) begin
               hs = p;
               have_h = 1;
            end else if (x[0] == 1'b0) begin
               held[s] = p;
            end else begin
               for (int c = 0; c < 4; c++) hs[c] = held[s][c] + p[c];
               have_h = 1;
            end
            if (!have_h) break;
            // vertical pairing
            if (sh == 1) begin
               tot = hs;
               n = 2;
               emit = 1;
            end else if (y[0] == 1'b0) begin
               pair_sum[s][dx] = hs;
            end else begin
               for (int c = 0; c < 4; c++) tot[c] = pair_sum[s][dx][c] + hs[c];
               n = (sw == 1) ? 2 : 4;
               emit = 1;
            end
            if (!emit) break;
            for (int c = 0; c < 4; c++) p[c] = ((tot[c] + n / 2) / n) & 32'hFFFF;
            r.level = LevelBits'(s + 1);
            r.col = PosBits'(dx);
            r.row = PosBits'(dy);
            r.red = PortChanBits'(p[0]);
            r.green = PortChanBits'(p[1]);
            r.blue = PortChanBits'(p[2]);
            r.alpha = PortChanBits'(p[3]);
            r.last_of_run = 1'b0;
            r.chain_done = (s + 1 == num_lvls);
            burst = {burst, r};
         end
         if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
         mip_queue = {mip_queue, burst};
      endfunction

      function void field_check(string fname, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t: mismatch %s expected %0h actual %0h", $time, fname, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(result_type act);
         result_type exp_r;
         results_seen++;
         if (mip_queue.size() == 0) begin
            $display("%0t: unexpected result expected none actual %p", $time, act);
            errors++;
            return;
         end
         exp_r = mip_queue.pop_front();
         field_check("level", 32'(exp_r.level), 32'(act.level));
         field_check("col", 32'(exp_r.col), 32'(act.col));
         field_check("row", 32'(exp_r.row), 32'(act.row));
         field_check("out_red", 32'(exp_r.red), 32'(act.red));
         field_check("out_green", 32'(exp_r.green), 32'(act.green));
         field_check("out_blue", 32'(exp_r.blue), 32'(act.blue));
         field_check("out_alpha", 32'(exp_r.alpha), 32'(act.alpha));
         field_check("last_of_run", 32'(exp_r.last_of_run), 32'(act.last_of_run));
         field_check("chain_done", 32'(exp_r.chain_done), 32'(act.chain_done));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_data;

   mbd_req_if req_ch();
   mbd_rsp_if rsp_ch();

   mipmap_box_downsample i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source)
   );

   mip_scoreboard sb;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;
   int unsigned phase_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check accepted items, random stall, watchdog
   initial begin
      result_type act;
      rsp_ch.ready <= 1'b0;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            act.level = rsp_ch.level;
            act.col = rsp_ch.col;
            act.row = rsp_ch.row;
            act.red = rsp_ch.out_red;
            act.green = rsp_ch.out_green;
            act.blue = rsp_ch.out_blue;
            act.alpha = rsp_ch.out_alpha;
            act.last_of_run = rsp_ch.last_of_run;
            act.chain_done = rsp_ch.chain_done;
            sb.check_result(act);
            quiet_cycles = 0;
         end else if (!reset && req_ch.valid && req_ch.ready) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, StallLimit);
            $display("DONE: errors detected");
            $finish;
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Pixel content: extremes, fixed patterns and random values
   function automatic pixel_type make_pixel(int unsigned kind);
      pixel_type px;
      case (kind)
         0: px = '0;
         1: px = '1;
         2: px = {4{16'h0001}};
         3: px = {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF};
         default: px = {$urandom, $urandom};
      endcase
      return px;
   endfunction

   // Idle for random cycles, then send one pixel and wait for its handshake
   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha} <= px;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_input(px);
   endtask

   // One register write; the caller drops the write enable afterwards
   task automatic write_csr(csr_index_type idx, logic [CsrDataBits-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // Drain, reconfigure and stream one image (or part of one)
   task automatic run_phase(int unsigned w, int unsigned h, int unsigned count, bit directed);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.mip_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      write_csr(CSR_BASE_WIDTH, CsrDataBits'(w));
      write_csr(CSR_BASE_HEIGHT, CsrDataBits'(h));
      // out-of-range indexes must be ignored and keep the frame position
      write_csr(csr_index_type'(2'd2), CsrDataBits'($urandom));
      write_csr(csr_index_type'(2'd3), CsrDataBits'($urandom));
      csr_we <= 1'b0;
      for (int i = 0; i < count; i++)
         send_pixel(make_pixel(directed ? (i % 4) : $urandom_range(9)));
      phase_count++;
   endtask

   initial begin
      sb = new();
      phase_count = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_BASE_WIDTH;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      {req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha} <= '0;
      send_idle_pct = 28;
      recv_idle_pct = 59;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 1x1 base, smallest chains, full-range values
      run_phase(1, 1, 3, 1);
      run_phase(2, 2, 8, 1);
      run_phase(3, 1, 6, 1);
      run_phase(1, 2, 6, 1);
      // random, first idling mix
      run_phase(4096, 1, 40, 0);
      run_phase(1, 4096, 24, 0);
      run_phase(8, 8, 64, 0);
      send_idle_pct = 59;
      recv_idle_pct = 28;
      run_phase(8191, 0, 30, 0);
      run_phase(5, 3, 24, 0);
      run_phase(7, 6, 30, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(16, 9, 24, 0);
      run_phase(3, 2, 12, 0);
      run_phase(2, 4096, 12, 0);

      req_ch.valid <= 1'b0;
      while (sb.mip_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d image settings, %0d base pixels, %0d mip pixels checked.",
               phase_count, sb.inputs_seen, sb.results_seen);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
